/* hw/rtl/fep_pkg.sv */
// ----------------------------------------------------------------------------
// fep_pkg - shared types and codes for the sorted request queue
// Operation codes and the command word from the controller to the datapath.
// ----------------------------------------------------------------------------
package fep_pkg;

    // operation codes carried on the mode field
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // ordering selected by the configuration bit
    localparam logic ORDER_FIFO = 1'b0;
    localparam logic ORDER_EDF  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // capture the incoming word
        logic compare;  // evaluate the per-entry compares
        logic update;   // insert, remove or clear and capture the result
    } fep_cmd_t;

endpackage

/* hw/rtl/fep_ctrl.sv */
// ----------------------------------------------------------------------------
// fep_ctrl - sequencer for the sorted request queue
// Steps each accepted word through compare, update and response cycles.
// ----------------------------------------------------------------------------
module fep_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output fep_pkg::fep_cmd_t cmd
);
    import fep_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    // hold state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= ST_CMP;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_CMP:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    state_reg <= ST_RESP;
                    done_reg  <= 1'b1;
                end
                ST_RESP:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    // decode commands for the datapath
    always_comb
    begin
        cmd.load    = (state_reg == ST_IDLE) && start;
        cmd.compare = (state_reg == ST_CMP);
        cmd.update  = (state_reg == ST_UPD);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/fep_datapath.sv */
// ----------------------------------------------------------------------------
// fep_datapath - sorted shift line of queue entries
// Parallel compares against every held entry, a prefix tree to find the
// insertion point, shift-up of the entries from there on, and shift-down of the whole line.
// ----------------------------------------------------------------------------
module fep_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int TAG_WIDTH   = 16,
    parameter int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fep_pkg::fep_cmd_t    cmd,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic [1:0]           mode,
    input  logic [KEY_WIDTH-1:0] deadline,
    input  logic [KEY_WIDTH-1:0] arrival_seq,
    input  logic [TAG_WIDTH-1:0] request_tag,
    output logic                 ok,
    output logic [KEY_WIDTH-1:0] out_deadline,
    output logic [KEY_WIDTH-1:0] out_arrival,
    output logic [TAG_WIDTH-1:0] out_tag,
    output logic                 head_valid,
    output logic [CNT_WIDTH-1:0] count
);
    import fep_pkg::*;

    localparam int LEVELS = $clog2(QUEUE_DEPTH);

    // configuration and captured word
    logic                 order_mode_reg;
    logic [1:0]           op_reg;
    logic [KEY_WIDTH-1:0] in_d_reg;
    logic [KEY_WIDTH-1:0] in_a_reg;
    logic [TAG_WIDTH-1:0] in_t_reg;

    // entry line, head at index 0
    logic [KEY_WIDTH-1:0] ent_d_reg [QUEUE_DEPTH];
    logic [KEY_WIDTH-1:0] ent_a_reg [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] ent_t_reg [QUEUE_DEPTH];
    logic [KEY_WIDTH-1:0] ent_d_next [QUEUE_DEPTH];
    logic [KEY_WIDTH-1:0] ent_a_next [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] ent_t_next [QUEUE_DEPTH];
    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;

    // compare results and result capture
    logic [QUEUE_DEPTH-1:0] hit_reg;
    logic [QUEUE_DEPTH-1:0] hit_next;
    logic [QUEUE_DEPTH-1:0] pfx;
    logic [QUEUE_DEPTH-1:0] pfx_prev;
    logic                   ok_reg;
    logic                   ok_next;
    logic                   popped_reg;
    logic                   popped_next;
    logic [KEY_WIDTH-1:0]   pd_reg;
    logic [KEY_WIDTH-1:0]   pa_reg;
    logic [TAG_WIDTH-1:0]   pt_reg;

    logic full;
    logic empty;

    assign full  = (count_reg == CNT_WIDTH'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // hold the ordering bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_mode_reg <= ORDER_FIFO;
        else if (cfg_we)
            order_mode_reg <= cfg_wdata;
    end

    // capture the incoming word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= mode;
            in_d_reg <= deadline;
            in_a_reg <= arrival_seq;
            in_t_reg <= request_tag;
        end
    end

    // compare the new request against every held entry
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (CNT_WIDTH'(i) >= count_reg)
                hit_next[i] = 1'b0;
            else if (order_mode_reg == ORDER_EDF && in_d_reg != ent_d_reg[i])
                hit_next[i] = (in_d_reg < ent_d_reg[i]);
            else
                hit_next[i] = (in_a_reg < ent_a_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
            hit_reg <= hit_next;
    end

    // find the first hit, or the slot just past the tail, with a prefix-OR tree
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            pfx[i] = hit_reg[i] | (CNT_WIDTH'(i) == count_reg);
        for (int k = 0; k < LEVELS; k++)
            pfx = pfx | (pfx << (1 << k));
        pfx_prev = pfx << 1;
    end

    // work out the next line, count and status
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ent_d_next[i] = ent_d_reg[i];
            ent_a_next[i] = ent_a_reg[i];
            ent_t_next[i] = ent_t_reg[i];
        end
        count_next  = count_reg;
        ok_next     = 1'b0;
        popped_next = 1'b0;
        case (op_reg)
            OP_PUSH:
            begin
                if (!full)
                begin
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (pfx_prev[i])
                        begin
                            ent_d_next[i] = ent_d_reg[(i > 0) ? i - 1 : 0];
                            ent_a_next[i] = ent_a_reg[(i > 0) ? i - 1 : 0];
                            ent_t_next[i] = ent_t_reg[(i > 0) ? i - 1 : 0];
                        end
                        else if (pfx[i])
                        begin
                            ent_d_next[i] = in_d_reg;
                            ent_a_next[i] = in_a_reg;
                            ent_t_next[i] = in_t_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_POP:
            begin
                if (!empty)
                begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        ent_d_next[i] = ent_d_reg[i + 1];
                        ent_a_next[i] = ent_a_reg[i + 1];
                        ent_t_next[i] = ent_t_reg[i + 1];
                    end
                    count_next  = count_reg - 1'b1;
                    ok_next     = 1'b1;
                    popped_next = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // advance the entry line and capture the popped head
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                ent_d_reg[i] <= ent_d_next[i];
                ent_a_reg[i] <= ent_a_next[i];
                ent_t_reg[i] <= ent_t_next[i];
            end
            pd_reg <= ent_d_reg[0];
            pa_reg <= ent_a_reg[0];
            pt_reg <= ent_t_reg[0];
        end
    end

    // hold count and result status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ok_reg     <= 1'b0;
            popped_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            count_reg  <= count_next;
            ok_reg     <= ok_next;
            popped_reg <= popped_next;
        end
    end

    // select the popped entry, the current head, or zero
    always_comb
    begin
        if (popped_reg)
        begin
            out_deadline = pd_reg;
            out_arrival  = pa_reg;
            out_tag      = pt_reg;
        end
        else if (!empty)
        begin
            out_deadline = ent_d_reg[0];
            out_arrival  = ent_a_reg[0];
            out_tag      = ent_t_reg[0];
        end
        else
        begin
            out_deadline = '0;
            out_arrival  = '0;
            out_tag      = '0;
        end
    end

    assign ok         = ok_reg;
    assign head_valid = !empty;
    assign count      = count_reg;

endmodule

/* hw/rtl/fifo_edf_priority_queue.sv */
// ----------------------------------------------------------------------------
// fifo_edf_priority_queue - bounded sorted request queue, FIFO or EDF order
// Top level: sequencer plus sorted entry line.
// ----------------------------------------------------------------------------
// Usage:
//   Drive mode (push, pop, clear), deadline, arrival_seq and request_tag
//   and raise start; the word is taken at a clock edge with start high and
//   busy low. busy then stays high until the result has been shown.
//   Each word gives one result word, on the result ports for exactly one
//   cycle while done is high: ok, the popped entry or the current head,
//   head_valid and count. The receiver cannot stall the result.
//   The block steps each word through compare, update and response
//   states; done rises with the update and the result is taken at the
//   edge where busy falls. The block then returns to idle, and a word is
//   taken only there, so no new word is taken before the last is through.
//   cfg_we with cfg_wdata writes the ordering bit (0 FIFO, 1 EDF); write it
//   only while idle. Held entries are not resorted.
//   Reset empties the queue and selects FIFO ordering; entry storage is
//   left as it is and only held entries are ever read.
// ----------------------------------------------------------------------------
module fifo_edf_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int TAG_WIDTH   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    output logic                                 done,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    input  logic [1:0]                           mode,
    input  logic [KEY_WIDTH-1:0]                 deadline,
    input  logic [KEY_WIDTH-1:0]                 arrival_seq,
    input  logic [TAG_WIDTH-1:0]                 request_tag,
    output logic                                 ok,
    output logic [KEY_WIDTH-1:0]                 out_deadline,
    output logic [KEY_WIDTH-1:0]                 out_arrival,
    output logic [TAG_WIDTH-1:0]                 out_tag,
    output logic                                 head_valid,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   count
);
    import fep_pkg::*;

    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    fep_cmd_t cmd;

    // sequence each word
    fep_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // hold and reorder the entries
    fep_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .TAG_WIDTH   (TAG_WIDTH),
        .CNT_WIDTH   (CNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mode          (mode),
        .deadline      (deadline),
        .arrival_seq   (arrival_seq),
        .request_tag   (request_tag),
        .ok            (ok),
        .out_deadline  (out_deadline),
        .out_arrival   (out_arrival),
        .out_tag       (out_tag),
        .head_valid    (head_valid),
        .count         (count)
    );

endmodule

/* test/tb_fifo_edf_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_edf_priority_queue - self-checking bench for the sorted request queue
// Drives push, pop, clear and unused words through the start/busy handshake
// under FIFO and EDF ordering, and tracks the sorted queue in a class that
// predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_fifo_edf_priority_queue;
    import fep_pkg::*;

    localparam int          QUEUE_DEPTH = 16;
    localparam int          KEY_WIDTH   = 32;
    localparam int          TAG_WIDTH   = 16;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          N_PHASES    = 12;
    localparam int          PHASE_WORDS = 120;

    typedef struct packed {
        logic        ok;
        logic [31:0] deadline;
        logic [31:0] arrival;
        logic [15:0] tag;
        logic        head_valid;
        logic [4:0]  count;
    } reply_t;

    // Sorted queue tracker: mirrors the held entries and the awaited replies
    class sorted_queue_tracker;
        localparam int DEPTH = 16;

        logic [31:0] ent_dl  [DEPTH];
        logic [31:0] ent_arr [DEPTH];
        logic [15:0] ent_tag [DEPTH];
        int unsigned held;
        logic        order_mode;
        reply_t      awaited_replies[$];

        int unsigned mismatches, checked, pushes, refused, pops, empty_pops;
        int unsigned clears, unused_ops, full_seen;

        function new();
            held       = 0;
            order_mode = ORDER_FIFO;
            mismatches = 0;
            checked    = 0;
            pushes     = 0;
            refused    = 0;
            pops       = 0;
            empty_pops = 0;
            clears     = 0;
            unused_ops = 0;
            full_seen  = 0;
        endfunction

        // true when the request orders strictly ahead of held entry i
        function bit orders_ahead(logic [31:0] d, logic [31:0] a, int unsigned i);
            if (order_mode == ORDER_EDF && d != ent_dl[i])
                return d < ent_dl[i];
            return a < ent_arr[i];
        endfunction

        // Apply one accepted word and queue the reply it should produce
        function void note_word(logic [1:0] op, logic [31:0] d, logic [31:0] a,
                                logic [15:0] t);
            reply_t      r;
            int unsigned pos;
            bit          found;
            bit          popped;
            r      = '0;
            found  = 1'b0;
            popped = 1'b0;
            case (op)
                OP_PUSH:
                begin
                    if (held < DEPTH)
                    begin
                        pos = held;
                        for (int unsigned i = 0; i < held; i++)
                        begin
                            if (!found && orders_ahead(d, a, i))
                            begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                        // open a slot at the insert point
                        for (int unsigned i = held; i > pos; i--)
                        begin
                            ent_dl[i]  = ent_dl[i-1];
                            ent_arr[i] = ent_arr[i-1];
                            ent_tag[i] = ent_tag[i-1];
                        end
                        ent_dl[pos]  = d;
                        ent_arr[pos] = a;
                        ent_tag[pos] = t;
                        held++;
                        r.ok = 1'b1;
                        pushes++;
                        if (held == DEPTH)
                            full_seen++;
                    end
                    else
                    begin
                        refused++;
                    end
                end
                OP_POP:
                begin
                    if (held > 0)
                    begin
                        r.deadline = ent_dl[0];
                        r.arrival  = ent_arr[0];
                        r.tag      = ent_tag[0];
                        // close the gap left by the head
                        for (int unsigned i = 1; i < held; i++)
                        begin
                            ent_dl[i-1]  = ent_dl[i];
                            ent_arr[i-1] = ent_arr[i];
                            ent_tag[i-1] = ent_tag[i];
                        end
                        held--;
                        popped = 1'b1;
                        r.ok   = 1'b1;
                        pops++;
                    end
                    else
                    begin
                        empty_pops++;
                    end
                end
                OP_CLEAR:
                begin
                    held = 0;
                    r.ok = 1'b1;
                    clears++;
                end
                default:
                begin
                    unused_ops++;
                end
            endcase
            // show the head unless a pop already filled the data fields
            if (!popped && held > 0)
            begin
                r.deadline = ent_dl[0];
                r.arrival  = ent_arr[0];
                r.tag      = ent_tag[0];
            end
            r.head_valid = (held > 0);
            r.count      = held[4:0];
            awaited_replies.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one result word with the oldest awaited reply
        function void check_word(reply_t got);
            reply_t want;
            if (awaited_replies.size() == 0)
            begin
                $error("result word with no reply awaited");
                mismatches++;
                return;
            end
            want = awaited_replies.pop_front();
            checked++;
            cmp_field("ok",           32'(want.ok),         32'(got.ok));
            cmp_field("out_deadline", want.deadline,        got.deadline);
            cmp_field("out_arrival",  want.arrival,         got.arrival);
            cmp_field("out_tag",      32'(want.tag),        32'(got.tag));
            cmp_field("head_valid",   32'(want.head_valid), 32'(got.head_valid));
            cmp_field("count",        32'(want.count),      32'(got.count));
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_wdata     = 1'b0;
    logic [1:0]  mode          = OP_PUSH;
    logic [31:0] deadline      = '0;
    logic [31:0] arrival_seq   = '0;
    logic [15:0] request_tag   = '0;
    logic        busy;
    logic        done;
    logic        ok;
    logic [31:0] out_deadline;
    logic [31:0] out_arrival;
    logic [15:0] out_tag;
    logic        head_valid;
    logic [4:0]  count;

    logic [31:0] next_arrival = '0;
    reply_t      seen;
    sorted_queue_tracker tracker = new();

    fifo_edf_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mode          (mode),
        .deadline      (deadline),
        .arrival_seq   (arrival_seq),
        .request_tag   (request_tag),
        .ok            (ok),
        .out_deadline  (out_deadline),
        .out_arrival   (out_arrival),
        .out_tag       (out_tag),
        .head_valid    (head_valid),
        .count         (count)
    );

    // Generate the clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Sample results and accepted words on the rising edge
    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            seen.ok         = ok;
            seen.deadline   = out_deadline;
            seen.arrival    = out_arrival;
            seen.tag        = out_tag;
            seen.head_valid = head_valid;
            seen.count      = count;
            tracker.check_word(seen);
        end
        if (rst_n && start && busy === 1'b0)
            tracker.note_word(mode, deadline, arrival_seq, request_tag);
    end

    // Offer one word and hold it until the block takes it
    task automatic send_word(input logic [1:0] op, input logic [31:0] d,
                             input logic [31:0] a, input logic [15:0] t);
        start         <= 1'b1;
        mode          <= op;
        deadline      <= d;
        arrival_seq   <= a;
        request_tag   <= t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Idle the sender for a number of cycles
    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every awaited reply has arrived, then let the block settle
    task automatic drain_queue_replies();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the ordering bit while the block is idle
    task automatic write_order(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.order_mode = value;
    endtask

    // Build one random word; push_pct sets how hard the queue is filled
    task automatic send_random_word(input int push_pct);
        int          r;
        logic [1:0]  op;
        logic [31:0] d;
        logic [31:0] a;
        r = $urandom_range(0, 99);
        if (r < 2)
            op = OP_CLEAR;
        else if (r < 3)
            op = OP_UNUSED;
        else if (r < 3 + push_pct)
            op = OP_PUSH;
        else
            op = OP_POP;
        // deadlines: full range, narrow bands for ties, and the extremes
        case ($urandom_range(0, 3))
            0:       d = $urandom;
            1:       d = $urandom_range(0, 7);
            2:       d = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: d = 32'h8000_0000 + $urandom_range(0, 3);
        endcase
        // arrivals: mostly a running sequence, with repeats and strays
        case ($urandom_range(0, 7))
            0:       a = $urandom;
            1:       a = next_arrival - 32'd1;
            2:       a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default:
            begin
                a            = next_arrival;
                next_arrival = next_arrival + 32'd1;
            end
        endcase
        send_word(op, d, a, 16'($urandom));
    endtask

    // Main sequence
    initial
    begin
        int  push_pct;
        bit  idling;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: FIFO ordering, empty pop, field extremes, arrival tie
        write_order(ORDER_FIFO);
        send_word(OP_POP,    32'h0,         32'h0,         16'h0);
        send_word(OP_PUSH,   32'h0,         32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_PUSH,   32'hFFFF_FFFF, 32'h0,         16'h0);
        send_word(OP_PUSH,   32'd5,         32'h0,         16'h1234);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_POP,    32'h0,         32'h0,         16'h0);
        send_word(OP_POP,    32'h0,         32'h0,         16'h0);
        send_word(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_POP,    32'h0,         32'h0,         16'h0);
        drain_queue_replies();

        // Directed: EDF ordering, deadline ties broken by arrival, full ties
        write_order(ORDER_EDF);
        send_word(OP_PUSH,   32'd100,       32'd7,         16'hA001);
        send_word(OP_PUSH,   32'd50,        32'd9,         16'hA002);
        send_word(OP_PUSH,   32'd100,       32'd3,         16'hA003);
        send_word(OP_PUSH,   32'd100,       32'd3,         16'hA004);
        send_word(OP_PUSH,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5555);
        send_word(OP_PUSH,   32'h0,         32'h0,         16'hAAAA);
        send_word(OP_POP,    32'h0,         32'h0,         16'h0);
        send_word(OP_UNUSED, 32'h0,         32'h0,         16'h0);
        send_word(OP_POP,    32'h0,         32'h0,         16'h0);
        send_word(OP_CLEAR,  32'h0,         32'h0,         16'h0);
        drain_queue_replies();

        // Random phases; held entries carry across ordering changes
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_queue_replies();
            if (ph == 0)
                write_order(ORDER_FIFO);
            else if (ph == 1)
                write_order(ORDER_EDF);
            else
                write_order(1'($urandom_range(0, 1)));
            case (ph % 3)
                0:       push_pct = 75;
                1:       push_pct = 50;
                default: push_pct = 30;
            endcase
            next_arrival = $urandom_range(0, 1) ? $urandom : 32'h0;
            idling       = (ph != N_PHASES - 1);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // idle in bursts, leaving stretches of back-to-back words in between
                if (idling && (n % 40) < 28 && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 10));
                send_random_word(push_pct);
            end
        end

        drain_queue_replies();
        $display("Checked %0d result words: %0d pushes, %0d refused on full, %0d pops,",
                 tracker.checked, tracker.pushes, tracker.refused, tracker.pops);
        $display("%0d pops on empty, %0d clears, %0d unused words, queue full %0d times",
                 tracker.empty_pops, tracker.clears, tracker.unused_ops, tracker.full_seen);
        if (tracker.mismatches == 0 && tracker.awaited_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fep_pkg.sv
hw/rtl/fep_ctrl.sv
hw/rtl/fep_datapath.sv
hw/rtl/fifo_edf_priority_queue.sv
test/tb_fifo_edf_priority_queue.sv
